// File: src/e2q_pkg.sv
`default_nettype none
package e2q_pkg;

  // field widths
  localparam int ANGLE_W = 16;
  localparam int COMP_W  = 16;

  // CORDIC iteration count and datapath width (Q29 in 32 bits)
  localparam int ITERS  = 16;
  localparam int IDX_W  = $clog2(ITERS);
  localparam int DATA_W = 32;
  localparam int FRAC   = 29;

  // pipeline depth
  localparam int FRONT_STAGES = 3;
  localparam int BACK_STAGES  = 4;
  localparam int LATENCY      = FRONT_STAGES + ITERS + BACK_STAGES;

  // fixed-point constants
  localparam logic [31:0]        RAD_SCALE   = 32'd2398794894;
  localparam logic signed [31:0] PI_Q29      = 32'sd1686629713;
  localparam logic signed [31:0] HALF_PI_Q29 = 32'sd843314857;
  localparam logic signed [31:0] GAIN_Q29    = 32'sd326016437;

  // one angle traveling through the CORDIC row
  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
    logic                     neg;
    logic                     flip;
  } lane_t;

  // arctangent of 2^-i in Q29
  function automatic logic signed [DATA_W-1:0] atan_q29(input logic [IDX_W-1:0] i);
    logic signed [DATA_W-1:0] r;
    case (i)
      0: r = 32'sd421657428;
      1: r = 32'sd248918915;
      2: r = 32'sd131521918;
      3: r = 32'sd66762579;
      4: r = 32'sd33510843;
      5: r = 32'sd16771758;
      6: r = 32'sd8387925;
      7: r = 32'sd4194219;
      8: r = 32'sd2097141;
      9: r = 32'sd1048575;
      default: r = 32'sd1 <<< (FRAC - int'(i));
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: src/e2q_front.sv
`default_nettype none
module e2q_front (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  input  wire logic signed [e2q_pkg::ANGLE_W-1:0] angle,
  output logic                                    out_valid,
  output e2q_pkg::lane_t                          lane
);

  logic                             v1_r, v2_r, v3_r;
  logic                             neg1_r, neg2_r;
  logic [e2q_pkg::ANGLE_W-1:0]      mag_r;
  logic signed [e2q_pkg::DATA_W-1:0] z2_r;
  logic [47:0]                      prod;
  e2q_pkg::lane_t                   lane_r, lane_nxt;

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // magnitude, then scale to half angle in radians
  assign prod = 48'(mag_r) * 48'(e2q_pkg::RAD_SCALE) + 48'd32768;

  // fold above pi/2 onto [0, pi/2]
  always_comb begin
    lane_nxt      = '0;
    lane_nxt.x    = e2q_pkg::GAIN_Q29;
    lane_nxt.neg  = neg2_r;
    lane_nxt.flip = z2_r > e2q_pkg::HALF_PI_Q29;
    lane_nxt.z    = lane_nxt.flip ? e2q_pkg::PI_Q29 - z2_r : z2_r;
  end

  always_ff @(posedge clk) begin
    neg1_r <= angle[e2q_pkg::ANGLE_W-1];
    mag_r  <= angle[e2q_pkg::ANGLE_W-1] ? e2q_pkg::ANGLE_W'(-angle)
                                        : e2q_pkg::ANGLE_W'(angle);
    neg2_r <= neg1_r;
    z2_r   <= signed'(prod[47:16]);
    lane_r <= lane_nxt;
  end

  assign out_valid = v3_r;
  assign lane      = lane_r;

endmodule
`default_nettype wire

// File: src/e2q_cell.sv
`default_nettype none
module e2q_cell (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [e2q_pkg::IDX_W-1:0]     idx,
  input  wire logic                          in_valid,
  input  wire e2q_pkg::lane_t [2:0]          lanes_in,
  output logic                               out_valid,
  output e2q_pkg::lane_t [2:0]               lanes_out
);

  logic                        valid_r;
  e2q_pkg::lane_t [2:0]        lanes_r, lanes_nxt;
  logic signed [e2q_pkg::DATA_W-1:0] t;

  assign t = e2q_pkg::atan_q29(idx);

  // one rotation per lane, direction from sign of residual angle
  always_comb begin
    lanes_nxt = lanes_in;
    for (int k = 0; k < 3; k++) begin
      if (!lanes_in[k].z[e2q_pkg::DATA_W-1]) begin
        lanes_nxt[k].x = lanes_in[k].x - (lanes_in[k].y >>> idx);
        lanes_nxt[k].y = lanes_in[k].y + (lanes_in[k].x >>> idx);
        lanes_nxt[k].z = lanes_in[k].z - t;
      end else begin
        lanes_nxt[k].x = lanes_in[k].x + (lanes_in[k].y >>> idx);
        lanes_nxt[k].y = lanes_in[k].y - (lanes_in[k].x >>> idx);
        lanes_nxt[k].z = lanes_in[k].z + t;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    lanes_r <= lanes_nxt;
  end

  assign out_valid = valid_r;
  assign lanes_out = lanes_r;

endmodule
`default_nettype wire

// File: src/e2q_back.sv
`default_nettype none
module e2q_back (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  input  wire e2q_pkg::lane_t [2:0]              lanes_in,
  output logic                                   out_valid,
  output logic signed [e2q_pkg::COMP_W-1:0]      scalar_part,
  output logic signed [e2q_pkg::COMP_W-1:0]      x_part,
  output logic signed [e2q_pkg::COMP_W-1:0]      y_part,
  output logic signed [e2q_pkg::COMP_W-1:0]      z_part
);

  localparam int SHIFT = 60 - e2q_pkg::COMP_W;
  localparam int VW    = 64 - SHIFT;
  localparam logic signed [VW-1:0] LIM = VW'(1) <<< (e2q_pkg::COMP_W - 2);

  logic [e2q_pkg::BACK_STAGES-1:0] v_r;
  logic signed [31:0] s_r [3], c_r [3];
  logic signed [31:0] s3_r, c3_r, cc_r, ss_r, sc_r, cs_r;
  logic signed [63:0] p_r [8];
  logic signed [63:0] sum [4];
  logic signed [e2q_pkg::COMP_W-1:0] res_r [4], res_nxt [4];

  function automatic logic signed [31:0] mul_q29(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [63:0] p;
    p = (64'(a) * 64'(b) + (64'sd1 <<< 28)) >>> 29;
    return p[31:0];
  endfunction

  function automatic logic signed [e2q_pkg::COMP_W-1:0] finish(
      input logic signed [63:0] q);
    logic signed [63:0] r;
    logic signed [VW-1:0] v;
    r = (q + (64'sd1 <<< (SHIFT - 1))) >>> SHIFT;
    v = r[VW-1:0];
    if (v > LIM) v = LIM;
    if (v < -LIM) v = -LIM;
    return v[e2q_pkg::COMP_W-1:0];
  endfunction

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[e2q_pkg::BACK_STAGES-2:0], in_valid};
    end
  end

  // final sums, negation, rounding, saturation
  always_comb begin
    sum[0] = -(p_r[0] + p_r[1]);
    sum[1] = -(p_r[2] - p_r[3]);
    sum[2] = -(p_r[4] + p_r[5]);
    sum[3] = -(p_r[6] - p_r[7]);
    for (int k = 0; k < 4; k++) res_nxt[k] = finish(sum[k]);
  end

  always_ff @(posedge clk) begin
    // sign and quadrant applied
    for (int k = 0; k < 3; k++) begin
      s_r[k] <= lanes_in[k].neg  ? -lanes_in[k].y : lanes_in[k].y;
      c_r[k] <= lanes_in[k].flip ? -lanes_in[k].x : lanes_in[k].x;
    end
    // two-factor products
    cc_r <= mul_q29(c_r[0], c_r[1]);
    ss_r <= mul_q29(s_r[0], s_r[1]);
    sc_r <= mul_q29(s_r[0], c_r[1]);
    cs_r <= mul_q29(c_r[0], s_r[1]);
    c3_r <= c_r[2];
    s3_r <= s_r[2];
    // three-factor products, Q58
    p_r[0] <= 64'(cc_r) * 64'(c3_r);
    p_r[1] <= 64'(ss_r) * 64'(s3_r);
    p_r[2] <= 64'(sc_r) * 64'(c3_r);
    p_r[3] <= 64'(cs_r) * 64'(s3_r);
    p_r[4] <= 64'(cs_r) * 64'(c3_r);
    p_r[5] <= 64'(sc_r) * 64'(s3_r);
    p_r[6] <= 64'(cc_r) * 64'(s3_r);
    p_r[7] <= 64'(ss_r) * 64'(c3_r);
    for (int k = 0; k < 4; k++) res_r[k] <= res_nxt[k];
  end

  assign out_valid   = v_r[e2q_pkg::BACK_STAGES-1];
  assign scalar_part = res_r[0];
  assign x_part      = res_r[1];
  assign y_part      = res_r[2];
  assign z_part      = res_r[3];

endmodule
`default_nettype wire

// File: src/euler_to_quaternion_top.sv
// Euler angle (ZYX) to attitude quaternion converter.
// Input: pulse start with in_roll_angle, in_pitch_angle, in_yaw_angle (signed,
// 1/128 degree). A transaction is taken at each clock edge where start is high
// and busy is low; busy is never raised, so one transaction per cycle is taken.
// Output: out_valid is high for one cycle with out_scalar_part, out_x_part,
// out_y_part, out_z_part (Q1.14, all four components negated, saturated to +-1).
// The pipeline has 3 front stages (magnitude, radian scaling, fold),
// one CORDIC cell per iteration (16), and 4 back stages (sign fix, two-factor
// products, three-factor products, round and saturate). Throughput is one
// result per cycle, set by the fully pipelined cell row.
// Results are delivered in order; the receiver cannot stall, so every result
// is shown exactly once. Synchronous reset drops everything in flight and
// clears out_valid; the block accepts transactions in the first cycle after.
`default_nettype none
module euler_to_quaternion_top (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic signed [e2q_pkg::ANGLE_W-1:0] in_roll_angle,
  input  wire logic signed [e2q_pkg::ANGLE_W-1:0] in_pitch_angle,
  input  wire logic signed [e2q_pkg::ANGLE_W-1:0] in_yaw_angle,
  output logic                                    out_valid,
  output logic signed [e2q_pkg::COMP_W-1:0]       out_scalar_part,
  output logic signed [e2q_pkg::COMP_W-1:0]       out_x_part,
  output logic signed [e2q_pkg::COMP_W-1:0]       out_y_part,
  output logic signed [e2q_pkg::COMP_W-1:0]       out_z_part
);

  logic                 accept;
  logic [2:0]           fv;
  e2q_pkg::lane_t [2:0] front_lanes;
  logic                 cv [e2q_pkg::ITERS+1];
  e2q_pkg::lane_t [2:0] cl [e2q_pkg::ITERS+1];

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // angle scaling, one unit per angle
  e2q_front u_front_roll (.clk, .rst_n, .in_valid(accept), .angle(in_roll_angle),
                          .out_valid(fv[0]), .lane(front_lanes[0]));
  e2q_front u_front_pitch (.clk, .rst_n, .in_valid(accept), .angle(in_pitch_angle),
                           .out_valid(fv[1]), .lane(front_lanes[1]));
  e2q_front u_front_yaw (.clk, .rst_n, .in_valid(accept), .angle(in_yaw_angle),
                         .out_valid(fv[2]), .lane(front_lanes[2]));

  assign cv[0] = fv[0];
  assign cl[0] = front_lanes;

  // CORDIC row, one iteration per cell
  for (genvar g = 0; g < e2q_pkg::ITERS; g++) begin : g_cell
    e2q_cell u_cell (
      .clk, .rst_n,
      .idx(e2q_pkg::IDX_W'(g)),
      .in_valid(cv[g]), .lanes_in(cl[g]),
      .out_valid(cv[g+1]), .lanes_out(cl[g+1])
    );
  end

  // quaternion products and output register
  e2q_back u_back (
    .clk, .rst_n,
    .in_valid(cv[e2q_pkg::ITERS]), .lanes_in(cl[e2q_pkg::ITERS]),
    .out_valid(out_valid),
    .scalar_part(out_scalar_part), .x_part(out_x_part),
    .y_part(out_y_part), .z_part(out_z_part)
  );

endmodule
`default_nettype wire

// File: src/e2q_checker.sv
`default_nettype none
module e2q_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               start,
  input wire logic                               busy,
  input wire logic                               out_valid,
  input wire logic signed [e2q_pkg::COMP_W-1:0]  out_scalar_part,
  input wire logic signed [e2q_pkg::COMP_W-1:0]  out_x_part
);

  localparam logic signed [e2q_pkg::COMP_W-1:0] ONE =
    e2q_pkg::COMP_W'(1) <<< (e2q_pkg::COMP_W - 2);

  // pipeline never refuses a transaction
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  // every result traces back to a transaction a fixed latency earlier
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, e2q_pkg::LATENCY))
    else $error("result without matching transaction");

  // saturation keeps the scalar and x components within plus or minus one
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_scalar_part <= ONE && out_scalar_part >= -ONE &&
                   out_x_part <= ONE && out_x_part >= -ONE))
    else $error("component out of range");

endmodule

bind euler_to_quaternion_top e2q_checker u_e2q_checker (
  .clk, .rst_n, .start, .busy, .out_valid, .out_scalar_part, .out_x_part
);
`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam longint RAD_K = 64'd2398794894;
  localparam longint PI_K = 64'd1686629713;
  localparam longint HALF_PI_K = 64'd843314857;
  localparam longint GAIN_K = 64'd326016437;
  localparam int N_ITER = 16;
  localparam int Q_W = 16;

  typedef struct packed {
    logic signed [Q_W-1:0] w;
    logic signed [Q_W-1:0] x;
    logic signed [Q_W-1:0] y;
    logic signed [Q_W-1:0] z;
  } quat_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [e2q_pkg::ANGLE_W-1:0] in_roll_angle;
  logic signed [e2q_pkg::ANGLE_W-1:0] in_pitch_angle;
  logic signed [e2q_pkg::ANGLE_W-1:0] in_yaw_angle;
  logic out_valid;
  logic signed [e2q_pkg::COMP_W-1:0] out_scalar_part;
  logic signed [e2q_pkg::COMP_W-1:0] out_x_part;
  logic signed [e2q_pkg::COMP_W-1:0] out_y_part;
  logic signed [e2q_pkg::COMP_W-1:0] out_z_part;

  quat_t expected_quats[$];
  int error_count;
  int idle_pct;
  int stall_cycles;

  euler_to_quaternion_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_roll_angle(in_roll_angle), .in_pitch_angle(in_pitch_angle),
    .in_yaw_angle(in_yaw_angle), .out_valid(out_valid),
    .out_scalar_part(out_scalar_part), .out_x_part(out_x_part),
    .out_y_part(out_y_part), .out_z_part(out_z_part)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // arctangent table, Q29
  function automatic longint atan_step(input int i);
    case (i)
      0: return 421657428;
      1: return 248918915;
      2: return 131521918;
      3: return 66762579;
      4: return 33510843;
      5: return 16771758;
      6: return 8387925;
      7: return 4194219;
      8: return 2097141;
      9: return 1048575;
      default: return longint'(1) << (29 - i);
    endcase
  endfunction

  // sine and cosine of half the angle, Q29
  task automatic half_angle_sincos(input logic signed [15:0] ang,
                                   output longint s, output longint c);
    longint a, z, x, y, dx, dy;
    bit neg, flip;
    a = ang;
    neg = a < 0;
    if (neg) a = -a;
    z = (a * RAD_K + 32768) >>> 16;
    flip = z > HALF_PI_K;
    if (flip) z = PI_K - z;
    x = GAIN_K;
    y = 0;
    for (int i = 0; i < N_ITER; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    c = flip ? -x : x;
    s = neg ? -y : y;
  endtask

  function automatic longint mul_q29(input longint a, input longint b);
    return (a * b + (longint'(1) << 28)) >>> 29;
  endfunction

  // Q58 to Q1.14 with rounding and saturation
  function automatic logic signed [Q_W-1:0] round_sat(input longint v);
    longint r, lim;
    lim = longint'(1) << (Q_W - 2);
    r = (v + (longint'(1) << (60 - Q_W - 1))) >>> (60 - Q_W);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r[Q_W-1:0];
  endfunction

  task automatic predict_quat(input logic signed [15:0] roll, pitch, yaw,
                              output quat_t q);
    longint s1, c1, s2, c2, s3, c3, cc, ss, sc, cs;
    half_angle_sincos(roll, s1, c1);
    half_angle_sincos(pitch, s2, c2);
    half_angle_sincos(yaw, s3, c3);
    cc = mul_q29(c1, c2);
    ss = mul_q29(s1, s2);
    sc = mul_q29(s1, c2);
    cs = mul_q29(c1, s2);
    q.w = round_sat(-(cc * c3 + ss * s3));
    q.x = round_sat(-(sc * c3 - cs * s3));
    q.y = round_sat(-(cs * c3 + sc * s3));
    q.z = round_sat(-(cc * s3 - ss * c3));
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // send one transaction, with random idle cycles before it
  task automatic send_angles(input logic signed [15:0] roll, pitch, yaw);
    quat_t q;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_roll_angle <= roll;
    in_pitch_angle <= pitch;
    in_yaw_angle <= yaw;
    do @(posedge clk); while (busy);
    predict_quat(roll, pitch, yaw, q);
    expected_quats.push_back(q);
  endtask

  task automatic release_start();
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    release_start();
    while (expected_quats.size() != 0) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    quat_t q;
    if (rst_n && out_valid) begin
      if (expected_quats.size() == 0) begin
        $display("ERROR %0t: result with nothing outstanding", $realtime);
        error_count++;
      end else begin
        q = expected_quats.pop_front();
        if (out_scalar_part !== q.w) report_mismatch("scalar", out_scalar_part, q.w);
        if (out_x_part !== q.x) report_mismatch("x", out_x_part, q.x);
        if (out_y_part !== q.y) report_mismatch("y", out_y_part, q.y);
        if (out_z_part !== q.z) report_mismatch("z", out_z_part, q.z);
      end
    end
  end

  // watchdog on cycles without any transaction or result
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    logic signed [15:0] corners[8] = '{16'sh0000, 16'sh7fff, -16'sh8000, 16'sh0001,
      -16'sh0001, 16'sd11520, -16'sd11520, 16'sd23040};
    send_angles(0, 0, 0);
    for (int i = 0; i < 8; i++) send_angles(corners[i], 0, 0);
    for (int i = 0; i < 8; i++) send_angles(0, corners[i], corners[7 - i]);
    send_angles(16'sh7fff, -16'sh8000, 16'sh7fff);
    send_angles(-16'sh8000, -16'sh8000, -16'sh8000);
    send_angles(16'sh5555, 16'shaaaa, 16'sh5555);
    // half angle exactly at the fold point
    send_angles(16'sd23040, 16'sd23041, 16'sd23039);
  endtask

  task automatic test_random(input int n, input int pct);
    idle_pct = pct;
    for (int i = 0; i < n; i++)
      send_angles(16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  initial begin
    error_count = 0;
    stall_cycles = 0;
    idle_pct = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_roll_angle = '0;
    in_pitch_angle = '0;
    in_yaw_angle = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    wait_drained();
    test_random(320, 12);
    wait_drained();
    test_random(320, 65);
    test_random(310, 0);
    release_start();
    while (expected_quats.size() != 0) @(posedge clk);
    repeat (e2q_pkg::LATENCY + 5) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
